// ===== rtl/sdrq_pkg.sv =====
`timescale 1ns / 1ps
package sdrq_pkg;

  localparam int SDRQ_DEPTH = 256;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 8;

  localparam logic [CNT_W-1:0] RUN_LIMIT  = CNT_W'(200);
  localparam logic [CNT_W-1:0] TRIG_COUNT = CNT_W'(60);
  localparam logic [CNT_W-1:0] TRIG_AFTER = CNT_W'(61);

  typedef enum logic [2:0] {
    ACT_RX_PUSH  = 3'd0,
    ACT_RX_POP   = 3'd1,
    ACT_MARK     = 3'd2,
    ACT_REWIND   = 3'd3,
    ACT_TEST     = 3'd4,
    ACT_TX_PUSH  = 3'd5,
    ACT_TX_GROUP = 3'd6,
    ACT_TX_POP   = 3'd7
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] data_in;
    logic              group_first;
    logic              group_last;
  } in_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              status_ok;
    logic              test_trigger;
    logic              drive_enable;
  } out_rsp_t;

endpackage

// ===== rtl/serial_dual_ring_queue_unit.sv =====
`timescale 1ns / 1ps
// The response strobe out_valid is high in the cycle after a request is taken.
// Throughput: one request per cycle while busy is low; both byte queues are 1R1W RAMs with registered read.
// Receiver cannot stall; each response is shown for exactly one cycle.
// Reset (rst_n, synchronous): pointers, count, flags and test byte clear; queue RAMs
// hold no reset value; busy is high for one cycle after reset release.
module serial_dual_ring_queue_unit import sdrq_pkg::*; #(
  parameter int QUEUE_DEPTH = SDRQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_req_t           in_req,
  output logic              out_valid,
  output out_rsp_t          out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic              rx_we, tx_we;
  logic [PW-1:0]     rx_waddr, rx_raddr, tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  sdrq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_raddr (rx_raddr),
    .rx_rdata (rx_rdata),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_raddr (tx_raddr),
    .tx_rdata (tx_rdata)
  );

  sdrq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_waddr),
    .wdata(in_req.data_in),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  sdrq_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_waddr),
    .wdata(in_req.data_in),
    .raddr(tx_raddr),
    .rdata(tx_rdata)
  );

endmodule

// ===== rtl/sdrq_ram.sv =====
`timescale 1ns / 1ps
module sdrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sdrq_ctrl.sv =====
`timescale 1ns / 1ps
module sdrq_ctrl import sdrq_pkg::*; #(
  parameter int QUEUE_DEPTH = SDRQ_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  in_req_t                        in_req,
  output logic                           out_valid,
  output out_rsp_t                       out_rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [BYTE_W-1:0]              cfg_data,
  output logic                           rx_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rx_waddr,
  output logic [$clog2(QUEUE_DEPTH)-1:0] rx_raddr,
  input  logic [BYTE_W-1:0]              rx_rdata,
  output logic                           tx_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] tx_waddr,
  output logic [$clog2(QUEUE_DEPTH)-1:0] tx_raddr,
  input  logic [BYTE_W-1:0]              tx_rdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  logic [PW-1:0]     rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt, rx_sp_r, rx_sp_nxt;
  logic [PW-1:0]     tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt, gs_r, gs_nxt;
  logic              gfail_r, gfail_nxt, drive_r, drive_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_base;
  logic [BYTE_W-1:0] cmd_r;
  logic              pend_r, pend_nxt, busy_r;
  logic              ovalid_r, dvalid_r, dvalid_nxt, sel_tx_r;
  logic              ok_r, ok_nxt, trig_r, trig_nxt;
  logic              acc, tx_full, fail_in, fail_out;
  logic [PW-1:0]     grp_start;

  assign acc       = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign tx_full   = (next_slot(tx_wp_r) == tx_rp_r);

  // count update of the previous rx pop, resolved from the read data
  always_comb begin
    cnt_base = cnt_r;
    if (pend_r) begin
      if (rx_rdata == cmd_r) begin
        cnt_base = (cnt_r >= RUN_LIMIT - CNT_W'(1)) ? RUN_LIMIT : cnt_r + CNT_W'(1);
      end else begin
        cnt_base = '0;
      end
    end
  end

  always_comb begin
    rx_wp_nxt  = rx_wp_r;
    rx_rp_nxt  = rx_rp_r;
    rx_sp_nxt  = rx_sp_r;
    tx_wp_nxt  = tx_wp_r;
    tx_rp_nxt  = tx_rp_r;
    gs_nxt     = gs_r;
    gfail_nxt  = gfail_r;
    drive_nxt  = drive_r;
    cnt_nxt    = cnt_base;
    pend_nxt   = 1'b0;
    dvalid_nxt = 1'b0;
    ok_nxt     = 1'b0;
    trig_nxt   = 1'b0;
    rx_we      = 1'b0;
    tx_we      = 1'b0;
    grp_start  = in_req.group_first ? tx_wp_r : gs_r;
    fail_in    = in_req.group_first ? 1'b0 : gfail_r;
    fail_out   = fail_in;
    if (acc) begin
      unique case (in_req.action)
        ACT_RX_PUSH: begin
          rx_we     = 1'b1;
          rx_wp_nxt = next_slot(rx_wp_r);
          ok_nxt    = 1'b1;
        end
        ACT_RX_POP: begin
          if (rx_rp_r != rx_wp_r) begin
            dvalid_nxt = 1'b1;
            pend_nxt   = 1'b1;
            rx_rp_nxt  = next_slot(rx_rp_r);
          end
        end
        ACT_MARK: begin
          rx_sp_nxt = rx_rp_r;
        end
        ACT_REWIND: begin
          rx_rp_nxt = rx_sp_r;
        end
        ACT_TEST: begin
          if (cnt_base == TRIG_COUNT) begin
            cnt_nxt  = TRIG_AFTER;
            trig_nxt = 1'b1;
          end
        end
        ACT_TX_PUSH: begin
          if (!tx_full) begin
            tx_we     = 1'b1;
            tx_wp_nxt = next_slot(tx_wp_r);
            ok_nxt    = 1'b1;
            drive_nxt = 1'b1;
          end
        end
        ACT_TX_GROUP: begin
          gs_nxt = grp_start;
          if (!fail_in) begin
            if (!tx_full) begin
              tx_we     = 1'b1;
              tx_wp_nxt = next_slot(tx_wp_r);
            end else begin
              tx_wp_nxt = grp_start;
              fail_out  = 1'b1;
            end
          end
          gfail_nxt = fail_out;
          ok_nxt    = ~fail_out;
          if (in_req.group_last && !fail_out) begin
            drive_nxt = 1'b1;
          end
        end
        ACT_TX_POP: begin
          if (tx_rp_r == tx_wp_r) begin
            drive_nxt = 1'b0;
          end else begin
            dvalid_nxt = 1'b1;
            tx_rp_nxt  = next_slot(tx_rp_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rx_waddr = rx_wp_r;
  assign rx_raddr = rx_rp_r;
  assign tx_waddr = tx_wp_r;
  assign tx_raddr = tx_rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r  <= '0;
      rx_rp_r  <= '0;
      rx_sp_r  <= '0;
      tx_wp_r  <= '0;
      tx_rp_r  <= '0;
      gs_r     <= '0;
      gfail_r  <= 1'b0;
      drive_r  <= 1'b0;
      cnt_r    <= '0;
      cmd_r    <= '0;
      pend_r   <= 1'b0;
      busy_r   <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      rx_wp_r  <= rx_wp_nxt;
      rx_rp_r  <= rx_rp_nxt;
      rx_sp_r  <= rx_sp_nxt;
      tx_wp_r  <= tx_wp_nxt;
      tx_rp_r  <= tx_rp_nxt;
      gs_r     <= gs_nxt;
      gfail_r  <= gfail_nxt;
      drive_r  <= drive_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      busy_r   <= 1'b0;
      ovalid_r <= acc;
      if (cfg_valid && cfg_ready) begin
        cmd_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      dvalid_r <= dvalid_nxt;
      sel_tx_r <= (in_req.action == ACT_TX_POP);
      ok_r     <= ok_nxt;
      trig_r   <= trig_nxt;
    end
  end

  assign out_valid            = ovalid_r;
  assign out_rsp.data_out     = dvalid_r ? (sel_tx_r ? tx_rdata : rx_rdata) : '0;
  assign out_rsp.data_valid   = dvalid_r;
  assign out_rsp.status_ok    = ok_r;
  assign out_rsp.test_trigger = trig_r;
  assign out_rsp.drive_enable = drive_r;

endmodule
